// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is high.
`define MPTC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mptc assertion failed");

// Checked on every rising edge, reset included.
`define MPTC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("mptc assertion failed");

`endif

// ----- rtl/mptc_pkg.sv -----
`timescale 1ns / 1ps

package mptc_pkg;

   localparam int INDEX_BITS = 28;
   localparam int DATA_LANES = 32;
   localparam int COUNT_BITS = 32;

   // only the low 32 bit lanes of a word can be counted
   localparam int LANE_USED = (DATA_LANES < 32) ? DATA_LANES : 32;
   localparam int LANE_IDX_BITS = $clog2(LANE_USED);
   localparam logic [5:0] LANE_LIMIT = 6'(LANE_USED);

   localparam logic [31:0] INDEX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic [31:0] BASE_PATTERN_RESET = 32'hAA55_AA55;

   typedef enum logic [1:0] {
      CMD_GENERATE  = 2'd0,
      CMD_CHECK     = 2'd1,
      CMD_READ_LANE = 2'd2,
      CMD_CLEAR     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CSR_BASE_PATTERN   = 2'd0,
      CSR_XOR_WITH_INDEX = 2'd1,
      CSR_REGION_BASE    = 2'd2
   } csr_index_type;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic clear;
      logic check;
      logic bank;
      logic rd_bank;
   } lane_ctrl_type;

   typedef struct packed {
      logic [31:0] write_data;
      logic        mismatch;
      logic [31:0] diff_bits;
      logic [31:0] error_total;
      logic        first_error_valid;
      logic [31:0] first_error_address;
      logic [31:0] lane_count;
   } rsp_type;

   function automatic count_type sat_inc(count_type v);
      return (&v) ? v : v + count_type'(1);
   endfunction

endpackage

// ----- rtl/mptc_lane.sv -----
`timescale 1ns / 1ps

// One bit lane: even-word and odd-word error counters.
module mptc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  mptc_pkg::lane_ctrl_type   ctrl,
   input  logic                      hit,
   output mptc_pkg::count_type       count_rd
);

   mptc_pkg::count_type even_ff, even_in;
   mptc_pkg::count_type odd_ff, odd_in;

   always_comb begin
      even_in = even_ff;
      odd_in  = odd_ff;
      if (ctrl.clear) begin
         even_in = '0;
         odd_in  = '0;
      end else if (ctrl.check && hit) begin
         if (ctrl.bank) begin
            odd_in = mptc_pkg::sat_inc(odd_ff);
         end else begin
            even_in = mptc_pkg::sat_inc(even_ff);
         end
      end
   end

   assign count_rd = ctrl.rd_bank ? odd_ff : even_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         even_ff <= '0;
         odd_ff  <= '0;
      end else begin
         even_ff <= even_in;
         odd_ff  <= odd_in;
      end
   end

endmodule

// ----- rtl/mptc_merge.sv -----
`timescale 1ns / 1ps

// Picks the requested lane's counter; lanes that do not exist read as zero.
module mptc_merge (
   input  mptc_pkg::count_type lane_counts [mptc_pkg::LANE_USED],
   input  logic [4:0]          lane_sel,
   output logic [31:0]         lane_count
);

   always_comb begin
      if ({1'b0, lane_sel} < mptc_pkg::LANE_LIMIT) begin
         lane_count = 32'(lane_counts[lane_sel[mptc_pkg::LANE_IDX_BITS-1:0]]);
      end else begin
         lane_count = '0;
      end
   end

endmodule

// ----- rtl/memory_pattern_test_checker.sv -----
`timescale 1ns / 1ps
// Each result is registered, in the skid entry while an earlier one waits.
// Throughput: one item per cycle while the skid entry is empty; the pattern,
// compare and all lane counter updates finish in the accepting cycle, and a
// two-entry output buffer keeps req_ready high while one result waits.
// Reset: synchronous; clears all counters and error status, and loads the
// registers with base pattern 0xAA55AA55, index XOR on, region base 0.
module memory_pattern_test_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [mptc_pkg::INDEX_BITS-1:0] req_word_index,
   input  logic [31:0] req_read_data,
   input  logic [5:0]  req_lane_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_write_data,
   output logic        rsp_mismatch,
   output logic [31:0] rsp_diff_bits,
   output logic [31:0] rsp_error_total,
   output logic        rsp_first_error_valid,
   output logic [31:0] rsp_first_error_address,
   output logic [31:0] rsp_lane_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] base_pattern_ff;
   logic        xor_index_ff;
   logic [31:0] region_base_ff;

   mptc_pkg::count_type error_count_ff, error_count_in;
   logic [31:0]         first_address_ff, first_address_in;
   logic                first_seen_ff, first_seen_in;

   mptc_pkg::rsp_type out_ff, out_in, skid_ff, skid_in, rsp_next;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic        accept;
   logic        pop;
   logic [31:0] idx;
   logic [31:0] expected;
   logic [31:0] diff_raw;
   logic        is_check;
   logic        mism;
   logic [31:0] lane_val;

   mptc_pkg::lane_ctrl_type lane_ctrl;
   mptc_pkg::count_type     lane_counts [mptc_pkg::LANE_USED];

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   assign idx      = 32'(req_word_index) & mptc_pkg::INDEX_MASK;
   assign expected = xor_index_ff ? (base_pattern_ff ^ idx) : base_pattern_ff;
   assign diff_raw = req_read_data ^ expected;
   assign is_check = (req_command == mptc_pkg::CMD_CHECK);
   assign mism     = is_check && (diff_raw != '0);

   assign lane_ctrl.clear   = accept && (req_command == mptc_pkg::CMD_CLEAR);
   assign lane_ctrl.check   = accept && is_check;
   assign lane_ctrl.bank    = idx[0];
   assign lane_ctrl.rd_bank = req_lane_select[5];

   for (genvar g = 0; g < mptc_pkg::LANE_USED; g++) begin : g_lane
      mptc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .hit      (diff_raw[g]),
         .count_rd (lane_counts[g])
      );
   end

   mptc_merge u_merge (
      .lane_counts (lane_counts),
      .lane_sel    (req_lane_select[4:0]),
      .lane_count  (lane_val)
   );

   // error status
   always_comb begin
      error_count_in   = error_count_ff;
      first_address_in = first_address_ff;
      first_seen_in    = first_seen_ff;
      if (accept) begin
         if (req_command == mptc_pkg::CMD_CLEAR) begin
            error_count_in   = '0;
            first_address_in = '0;
            first_seen_in    = 1'b0;
         end else if (mism) begin
            error_count_in = mptc_pkg::sat_inc(error_count_ff);
            if (!first_seen_ff) begin
               first_seen_in    = 1'b1;
               first_address_in = region_base_ff + {idx[29:0], 2'b00};
            end
         end
      end
   end

   always_comb begin
      rsp_next.write_data          = expected;
      rsp_next.mismatch            = mism;
      rsp_next.diff_bits           = is_check ? diff_raw : '0;
      rsp_next.error_total         = 32'(error_count_in);
      rsp_next.first_error_valid   = first_seen_in;
      rsp_next.first_error_address = first_seen_in ? first_address_in : '0;
      rsp_next.lane_count          =
         (req_command == mptc_pkg::CMD_READ_LANE) ? lane_val : '0;
   end

   // two-entry output buffer, skid entry drains into the output first
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_in       = rsp_next;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_next;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pattern_ff  <= mptc_pkg::BASE_PATTERN_RESET;
         xor_index_ff     <= 1'b1;
         region_base_ff   <= '0;
         error_count_ff   <= '0;
         first_address_ff <= '0;
         first_seen_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         error_count_ff   <= error_count_in;
         first_address_ff <= first_address_in;
         first_seen_ff    <= first_seen_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               mptc_pkg::CSR_BASE_PATTERN:   base_pattern_ff <= csr_data;
               mptc_pkg::CSR_XOR_WITH_INDEX: xor_index_ff    <= csr_data[0];
               mptc_pkg::CSR_REGION_BASE:    region_base_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_write_data          = out_ff.write_data;
   assign rsp_mismatch            = out_ff.mismatch;
   assign rsp_diff_bits           = out_ff.diff_bits;
   assign rsp_error_total         = out_ff.error_total;
   assign rsp_first_error_valid   = out_ff.first_error_valid;
   assign rsp_first_error_address = out_ff.first_error_address;
   assign rsp_lane_count          = out_ff.lane_count;

endmodule

// ----- rtl/mptc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_write_data,
   input logic        rsp_mismatch,
   input logic [31:0] rsp_diff_bits,
   input logic [31:0] rsp_error_total,
   input logic        rsp_first_error_valid,
   input logic [31:0] rsp_first_error_address
);

   logic diff_nonzero;
   logic status_set;
   logic addr_zero;

   assign diff_nonzero = (rsp_diff_bits != '0);
   assign status_set   = rsp_first_error_valid && (rsp_error_total != '0);
   assign addr_zero    = (rsp_first_error_address == '0);

   // a mismatch flag agrees with the difference word
   `MPTC_ASSERT(a_mismatch_diff, clock, reset, rsp_valid |-> (rsp_mismatch == diff_nonzero))

   // a mismatch is always reflected in the error status of the same item
   `MPTC_ASSERT(a_mismatch_status, clock, reset, (rsp_valid && rsp_mismatch) |-> status_set)

   // no first error recorded means the address reads as zero
   `MPTC_ASSERT(a_first_addr_zero, clock, reset, (rsp_valid && !rsp_first_error_valid) |-> addr_zero)

   // a stalled item holds
   `MPTC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_data))

   `MPTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind memory_pattern_test_checker mptc_checker u_mptc_checker (.*);

// ----- test/tb_memory_pattern_test_checker.sv -----
`timescale 1ns / 1ps

module tb_memory_pattern_test_checker;

   // index 3 decodes to no register
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [27:0] INDEX_TOP = 28'hFFF_FFFF;

   typedef struct {
      mptc_pkg::command_type cmd;
      logic [27:0] index;
      logic [31:0] rdata;
      logic [5:0]  lane;
   } pattern_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = mptc_pkg::CMD_GENERATE;
   logic [27:0] req_word_index = '0;
   logic [31:0] req_read_data = '0;
   logic [5:0]  req_lane_select = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_write_data;
   logic        rsp_mismatch;
   logic [31:0] rsp_diff_bits;
   logic [31:0] rsp_error_total;
   logic        rsp_first_error_valid;
   logic [31:0] rsp_first_error_address;
   logic [31:0] rsp_lane_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = mptc_pkg::CSR_BASE_PATTERN;
   logic [31:0] csr_data = '0;

   memory_pattern_test_checker uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_command             (req_command),
      .req_word_index          (req_word_index),
      .req_read_data           (req_read_data),
      .req_lane_select         (req_lane_select),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_write_data          (rsp_write_data),
      .rsp_mismatch            (rsp_mismatch),
      .rsp_diff_bits           (rsp_diff_bits),
      .rsp_error_total         (rsp_error_total),
      .rsp_first_error_valid   (rsp_first_error_valid),
      .rsp_first_error_address (rsp_first_error_address),
      .rsp_lane_count          (rsp_lane_count),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the checker registers and status
   logic [31:0] cfg_pattern;
   logic        cfg_xor;
   logic [31:0] cfg_region;
   logic [31:0] err_total_m;
   logic [31:0] first_addr_m;
   logic        seen_m;
   logic [31:0] lane_cnt_m [2][32];

   pattern_req_type   pending_q[$];
   mptc_pkg::rsp_type expected_rsp_q[$];
   pattern_req_type   cur_item;
   pattern_req_type   next_item;
   mptc_pkg::rsp_type exp_rsp;
   int                burst_left = 0;
   int                gap_left = 0;
   int                stall_cycle = 0;
   int                error_events = 0;

   function automatic logic [31:0] word_pattern(logic [27:0] idx);
      return cfg_xor ? (cfg_pattern ^ {4'b0, idx}) : cfg_pattern;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic void clear_status();
      err_total_m = '0;
      first_addr_m = '0;
      seen_m = 1'b0;
      for (int b = 0; b < 2; b++)
         for (int l = 0; l < 32; l++)
            lane_cnt_m[b][l] = '0;
   endfunction

   function automatic mptc_pkg::rsp_type predict_checker_rsp(pattern_req_type it);
      mptc_pkg::rsp_type r;
      logic [31:0]       expw;
      logic [31:0]       diff;
      expw = word_pattern(it.index);
      r = '0;
      r.write_data = expw;
      case (it.cmd)
         mptc_pkg::CMD_CHECK: begin
            diff = it.rdata ^ expw;
            r.diff_bits = diff;
            if (diff != '0) begin
               r.mismatch = 1'b1;
               if (!seen_m) begin
                  seen_m = 1'b1;
                  first_addr_m = cfg_region + {2'b00, it.index, 2'b00};
               end
               err_total_m = bump(err_total_m);
               for (int l = 0; l < 32; l++)
                  if (diff[l])
                     lane_cnt_m[it.index[0]][l] = bump(lane_cnt_m[it.index[0]][l]);
            end
         end
         mptc_pkg::CMD_READ_LANE: r.lane_count = lane_cnt_m[it.lane[5]][it.lane[4:0]];
         mptc_pkg::CMD_CLEAR: clear_status();
         default: ;
      endcase
      r.error_total = err_total_m;
      r.first_error_valid = seen_m;
      r.first_error_address = seen_m ? first_addr_m : 32'd0;
      return r;
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_checker_rsp(cur_item));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               next_item = pending_q.pop_front();
               cur_item <= next_item;
               req_command <= next_item.cmd;
               req_word_index <= next_item.index;
               req_read_data <= next_item.rdata;
               req_lane_select <= next_item.lane;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                            : $urandom_range(1, 12);
                  gap_left <= $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         error_events++;
         if (error_events <= 10)
            $display("%s mismatch: expected %h actual %h", name, e, a);
      end
   endtask

   // receiver: stall pattern changes with bits 8:6 of the cycle counter
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               error_events++;
               if (error_events <= 10)
                  $display("result with no item pending: write_data %h", rsp_write_data);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("write_data", exp_rsp.write_data, rsp_write_data);
               check_field("mismatch", 32'(exp_rsp.mismatch), 32'(rsp_mismatch));
               check_field("diff_bits", exp_rsp.diff_bits, rsp_diff_bits);
               check_field("error_total", exp_rsp.error_total, rsp_error_total);
               check_field("first_error_valid", 32'(exp_rsp.first_error_valid),
                           32'(rsp_first_error_valid));
               check_field("first_error_address", exp_rsp.first_error_address,
                           rsp_first_error_address);
               check_field("lane_count", exp_rsp.lane_count, rsp_lane_count);
            end
         end
         stall_cycle <= stall_cycle + 1;
         case (stall_cycle[8:6])
            3'd0, 3'd1: rsp_ready <= 1'b1;
            3'd2: rsp_ready <= 1'($urandom_range(0, 1));
            3'd3: rsp_ready <= (stall_cycle[2:0] < 3'd3);
            3'd4: rsp_ready <= ($urandom_range(0, 9) != 0);
            3'd5: rsp_ready <= (stall_cycle[4:0] == 5'd0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mptc_pkg::CSR_BASE_PATTERN: cfg_pattern = value;
         mptc_pkg::CSR_XOR_WITH_INDEX: cfg_xor = value[0];
         mptc_pkg::CSR_REGION_BASE: cfg_region = value;
         default: ;
      endcase
   endtask

   task automatic push_item(mptc_pkg::command_type cmd, logic [27:0] idx,
                            logic [31:0] rd, logic [5:0] lane);
      pattern_req_type it;
      it.cmd = cmd;
      it.index = idx;
      it.rdata = rd;
      it.lane = lane;
      pending_q.push_back(it);
   endtask

   task automatic push_random(int n);
      logic [27:0] idx;
      logic [31:0] rd;
      logic [5:0]  lane;
      int          pick;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: idx = '0;
            1: idx = INDEX_TOP;
            2, 3: idx = 28'($urandom_range(0, 15));
            default: idx = 28'($urandom);
         endcase
         rd = $urandom;
         lane = 6'($urandom_range(0, 63));
         pick = int'($urandom_range(0, 99));
         if (pick < 20) begin
            push_item(mptc_pkg::CMD_GENERATE, idx, rd, lane);
         end else if (pick < 75) begin
            // half clean reads, others with one or two flipped bits, random data or all bits flipped
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: rd = word_pattern(idx);
               5, 6: rd = word_pattern(idx) ^ (32'd1 << $urandom_range(0, 31));
               7: rd = word_pattern(idx) ^ (32'd1 << $urandom_range(0, 31))
                       ^ (32'd1 << $urandom_range(0, 31));
               8: rd = $urandom;
               default: rd = ~word_pattern(idx);
            endcase
            push_item(mptc_pkg::CMD_CHECK, idx, rd, lane);
         end else if (pick < 95) begin
            push_item(mptc_pkg::CMD_READ_LANE, idx, rd, lane);
         end else begin
            push_item(mptc_pkg::CMD_CLEAR, idx, rd, lane);
         end
      end
   endtask

   // poll on the falling edge so queue and valid state are settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin
      cfg_pattern = mptc_pkg::BASE_PATTERN_RESET;
      cfg_xor = 1'b1;
      cfg_region = '0;
      clear_status();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_item(mptc_pkg::CMD_GENERATE, 28'd0, 32'd0, 6'd0);
      push_item(mptc_pkg::CMD_GENERATE, INDEX_TOP, 32'hFFFF_FFFF, 6'd63);
      push_item(mptc_pkg::CMD_CHECK, 28'd1, word_pattern(28'd1), 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd6, ~word_pattern(28'd6), 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd7, ~word_pattern(28'd7), 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd4, word_pattern(28'd4) ^ 32'h1, 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd9, word_pattern(28'd9) ^ 32'h8000_0000, 6'd0);
      push_item(mptc_pkg::CMD_CHECK, INDEX_TOP, 32'd0, 6'd63);
      push_item(mptc_pkg::CMD_CHECK, 28'd0, 32'hFFFF_FFFF, 6'd0);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd0);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd31);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd32);
      push_item(mptc_pkg::CMD_READ_LANE, INDEX_TOP, 32'hFFFF_FFFF, 6'd63);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd3, 32'd0, 6'd5);
      push_item(mptc_pkg::CMD_CLEAR, 28'd0, 32'd0, 6'd0);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd63);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd3, word_pattern(28'd3), 6'd0);
      // first error after a clear is recorded again
      push_item(mptc_pkg::CMD_CHECK, 28'd3, word_pattern(28'd3) ^ 32'h0001_0000, 6'd0);
      push_item(mptc_pkg::CMD_CHECK, 28'd5, word_pattern(28'd5) ^ 32'h0000_0100, 6'd0);
      push_item(mptc_pkg::CMD_READ_LANE, 28'd0, 32'd0, 6'd48);
      push_item(mptc_pkg::CMD_GENERATE, 28'd12345, 32'd0, 6'd0);
      push_random(80);
      wait_drained();

      csr_write(mptc_pkg::CSR_BASE_PATTERN, 32'h0000_0000);
      csr_write(mptc_pkg::CSR_XOR_WITH_INDEX, 32'd0);
      csr_write(mptc_pkg::CSR_REGION_BASE, 32'h0000_0000);
      csr_write(CSR_UNUSED, $urandom);
      @(negedge clock);
      push_random(60);
      wait_drained();

      csr_write(mptc_pkg::CSR_BASE_PATTERN, 32'hFFFF_FFFF);
      csr_write(mptc_pkg::CSR_XOR_WITH_INDEX, 32'hFFFF_FFFF);
      csr_write(mptc_pkg::CSR_REGION_BASE, 32'hFFFF_FFFF);
      @(negedge clock);
      push_item(mptc_pkg::CMD_CLEAR, 28'd0, 32'd0, 6'd0);
      // address of the first error wraps past the top
      push_item(mptc_pkg::CMD_CHECK, INDEX_TOP, 32'd0, 6'd0);
      push_random(60);
      wait_drained();

      csr_write(CSR_UNUSED, 32'h0000_0001);
      csr_write(mptc_pkg::CSR_BASE_PATTERN, 32'h55AA_55AA);
      csr_write(mptc_pkg::CSR_XOR_WITH_INDEX, 32'hFFFF_FFFE);
      csr_write(mptc_pkg::CSR_REGION_BASE, $urandom);
      @(negedge clock);
      push_random(80);
      wait_drained();

      csr_write(mptc_pkg::CSR_BASE_PATTERN, $urandom);
      csr_write(mptc_pkg::CSR_XOR_WITH_INDEX, 32'd1);
      csr_write(mptc_pkg::CSR_REGION_BASE, 32'h0000_1000);
      @(negedge clock);
      push_random(80);
      wait_drained();

      if (error_events == 0 && expected_rsp_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
